// ===== rtl/cmu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cmu_pkg;

  // Fixed field widths of the stream items
  localparam int CH_W       = 8;
  localparam int COORD_IN_W = 12;
  localparam int COUNT_W    = 16;
  localparam int COUNT_MAX  = 65535;

  // Packed payload widths
  localparam int IN_DATA_W  = 48;  // l, a, b, x, y
  localparam int OUT_DATA_W = 64;  // mean l, a, b, x, y, count

  // Parameter defaults
  localparam int MAX_PIXELS_DEF = 65535;
  localparam int COORD_BITS_DEF = 12;

  // Quantity currently handed to the shared divider
  typedef enum logic [2:0] {
    LANE_L = 3'd0,
    LANE_A = 3'd1,
    LANE_B = 3'd2,
    LANE_X = 3'd3,
    LANE_Y = 3'd4
  } lane_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  acc_en;     // item accepted this cycle
    logic  div_start;  // load the divider with the selected sum
    logic  cap_en;     // store the finished quotient of the selected lane
    logic  load_out;   // move the means to the output register, clear sums
    lane_t lane;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;  // quotient ready this cycle
    logic out_free;  // output register can take a new result
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/cmu_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmu_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [DVD_W-1:0] quotient,
  output logic                  done
);

  localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              qbit;

  // One restoring step: bring down the next dividend bit and try a subtract
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign qbit  = (trial >= {1'b0, divisor});

  always_comb begin
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[DVD_W-2:0], 1'b0};
      quo_nxt  = {quo_r[DVD_W-2:0], qbit};
      rem_nxt  = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      step_nxt = step_r + STEP_W'(1);
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Operand registers need no reset
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

// ===== rtl/cmu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmu_datapath #(
  parameter int MAX_PIXELS = cmu_pkg::MAX_PIXELS_DEF,
  parameter int COORD_BITS = cmu_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cmu_pkg::cmd_t                  cmd,
  output cmu_pkg::sts_t                       sts,
  input  wire logic [cmu_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [cmu_pkg::OUT_DATA_W-1:0] out_tdata
);

  import cmu_pkg::*;

  localparam int CNT_BOUND = (MAX_PIXELS < COUNT_MAX) ? MAX_PIXELS : COUNT_MAX;
  localparam int CNT_W     = $clog2(CNT_BOUND + 1);
  localparam int CRD_W     = (COORD_BITS < COORD_IN_W) ? COORD_BITS : COORD_IN_W;
  localparam int SUMC_W    = CH_W + CNT_W;
  localparam int SUMP_W    = CRD_W + CNT_W;
  localparam int DIV_W     = (SUMC_W > SUMP_W) ? SUMC_W : SUMP_W;
  localparam int QX_W      = DIV_W + COORD_IN_W;

  logic [CH_W-1:0]       px_l, px_a, px_b;
  logic [COORD_IN_W-1:0] px_x, px_y;

  logic [SUMC_W-1:0] sum_l_r, sum_a_r, sum_b_r;
  logic [SUMP_W-1:0] sum_x_r, sum_y_r;
  logic [CNT_W-1:0]  count_r;
  logic              take_px;

  logic [DIV_W-1:0]  dvd;
  logic [DIV_W-1:0]  quo;
  logic              div_done;
  logic [QX_W-1:0]   quo_wide;

  logic [CH_W-1:0]       res_l_r, res_a_r, res_b_r;
  logic [COORD_IN_W-1:0] res_x_r, res_y_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_valid_r;

  // Unpack the input item
  assign px_l = in_tdata[7:0];
  assign px_a = in_tdata[15:8];
  assign px_b = in_tdata[23:16];
  assign px_x = in_tdata[35:24];
  assign px_y = in_tdata[47:36];

  // Accumulate a present pixel until the count bound is reached
  assign take_px = cmd.acc_en && in_tuser && (count_r < CNT_W'(CNT_BOUND));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_l_r <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      count_r <= '0;
    end else if (cmd.load_out) begin
      sum_l_r <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      count_r <= '0;
    end else if (take_px) begin
      sum_l_r <= sum_l_r + SUMC_W'(px_l);
      sum_a_r <= sum_a_r + SUMC_W'(px_a);
      sum_b_r <= sum_b_r + SUMC_W'(px_b);
      sum_x_r <= sum_x_r + SUMP_W'(px_x[CRD_W-1:0]);
      sum_y_r <= sum_y_r + SUMP_W'(px_y[CRD_W-1:0]);
      count_r <= count_r + CNT_W'(1);
    end
  end

  // Select the sum for the shared divider
  always_comb begin
    unique case (cmd.lane)
      LANE_L:  dvd = DIV_W'(sum_l_r);
      LANE_A:  dvd = DIV_W'(sum_a_r);
      LANE_B:  dvd = DIV_W'(sum_b_r);
      LANE_X:  dvd = DIV_W'(sum_x_r);
      LANE_Y:  dvd = DIV_W'(sum_y_r);
      default: dvd = '0;
    endcase
  end

  cmu_div #(
    .DVD_W (DIV_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (count_r),
    .quotient (quo),
    .done     (div_done)
  );

  // An empty cluster gives zero means
  assign quo_wide = (count_r == '0) ? '0 : QX_W'(quo);

  // Store the finished quotient in its lane
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.lane)
        LANE_L:  res_l_r <= quo_wide[CH_W-1:0];
        LANE_A:  res_a_r <= quo_wide[CH_W-1:0];
        LANE_B:  res_b_r <= quo_wide[CH_W-1:0];
        LANE_X:  res_x_r <= quo_wide[COORD_IN_W-1:0];
        LANE_Y:  res_y_r <= quo_wide[COORD_IN_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register: hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {COUNT_W'(count_r), res_y_r, res_x_r, res_b_r, res_a_r, res_l_r};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

`default_nettype wire

// ===== rtl/cmu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic          in_tlast,
  input  wire cmu_pkg::sts_t sts,
  output cmu_pkg::cmd_t      cmd
);

  import cmu_pkg::*;

  typedef enum logic [3:0] {
    S_ACCUM  = 4'b0001,
    S_START  = 4'b0010,
    S_WAIT   = 4'b0100,
    S_OUTPUT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  lane_t  lane_r, lane_nxt;
  lane_t  lane_inc;
  logic   accept;

  assign in_tready = (state_r == S_ACCUM);
  assign accept    = in_tvalid && in_tready;

  // Next quantity to divide
  always_comb begin
    unique case (lane_r)
      LANE_L:  lane_inc = LANE_A;
      LANE_A:  lane_inc = LANE_B;
      LANE_B:  lane_inc = LANE_X;
      LANE_X:  lane_inc = LANE_Y;
      LANE_Y:  lane_inc = LANE_L;
      default: lane_inc = LANE_L;
    endcase
  end

  // Sequence: accumulate, divide each sum in turn, hand off the result
  always_comb begin
    state_nxt     = state_r;
    lane_nxt      = lane_r;
    cmd.acc_en    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.cap_en    = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.lane      = lane_r;
    unique case (state_r)
      S_ACCUM: begin
        cmd.acc_en = accept;
        if (accept && in_tlast) begin
          lane_nxt  = LANE_L;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_en = 1'b1;
          lane_nxt   = lane_inc;
          state_nxt  = (lane_r == LANE_Y) ? S_OUTPUT : S_START;
        end
      end
      S_OUTPUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_ACCUM;
        end
      end
      default: state_nxt = S_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACCUM;
      lane_r  <= LANE_L;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cluster_mean_update_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Payload
// in_      slave      tdata: pixel l, a, b, x, y; tuser: pixel present; tlast: last
// out_     master     tdata: mean l, a, b, x, y, pixel count
//
// Pixels are taken one per cycle while the cluster accumulates.
// An item with tlast starts five divisions on one shared radix-2 divider;
// the block takes no item until all five are done and the means have been
// loaded into the output register, which waits until that register is free.
// Reset (synchronous, active low) clears sums, count and the output valid.
// The result sits in an output register; a stalled output blocks only the
// handoff of the next cluster's result, not the accumulation before it.

module cluster_mean_update_top #(
  parameter int MAX_PIXELS = cmu_pkg::MAX_PIXELS_DEF,
  parameter int COORD_BITS = cmu_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // pixel_l[7:0], pixel_a[15:8], pixel_b[23:16], pixel_x[35:24], pixel_y[47:36]
  input  wire logic [cmu_pkg::IN_DATA_W-1:0]  in_tdata,
  // pixel_present[0]
  input  wire logic                           in_tuser,
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // mean_l[7:0], mean_a[15:8], mean_b[23:16], mean_x[35:24], mean_y[47:36],
  // count[63:48]
  output logic      [cmu_pkg::OUT_DATA_W-1:0] out_tdata
);

  import cmu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cmu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .sts       (sts),
    .cmd       (cmd)
  );

  cmu_datapath #(
    .MAX_PIXELS (MAX_PIXELS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/cmu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmu_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           in_tlast,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [cmu_pkg::OUT_DATA_W-1:0] out_tdata
);

  import cmu_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Stop taking items once a cluster closes
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("item taken while the means are computed");

  // Empty cluster reports zero means
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[63:48] == 16'd0) |-> (out_tdata[47:0] == 48'd0))
    else $error("nonzero mean for an empty cluster");

  // Come out of reset empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind cluster_mean_update_top cmu_checker u_cmu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== sim/cluster_mean_update_top_test.sv =====
`timescale 1ns / 1ps

module cluster_mean_update_top_test;

  import cmu_pkg::*;

  localparam int MAX_PIX     = MAX_PIXELS_DEF;
  localparam int COUNT_BOUND = (MAX_PIX < COUNT_MAX) ? MAX_PIX : COUNT_MAX;
  localparam int RUN_LIMIT   = 1_000_000;
  localparam int DRAIN_WAIT  = 200;  // longer than the division pass

  // One expected cluster result
  typedef struct {
    logic [CH_W-1:0]       l;
    logic [CH_W-1:0]       a;
    logic [CH_W-1:0]       b;
    logic [COORD_IN_W-1:0] x;
    logic [COORD_IN_W-1:0] y;
    logic [COUNT_W-1:0]    n;
  } cluster_mean_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Running sums of the cluster being collected
  logic [23:0] acc_l, acc_a, acc_b;
  logic [27:0] acc_x, acc_y;
  logic [15:0] acc_n;

  cluster_mean_t mean_queue[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  cluster_mean_update_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("FAIL cluster_mean_update_top");
      $finish;
    end
  end

  function automatic logic [27:0] trunc_mean(input logic [27:0] total, input logic [15:0] n);
    if (n == 0) return '0;
    return total / n;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_pixel(input logic [7:0] l, input logic [7:0] a,
                                                      input logic [7:0] b, input logic [11:0] x,
                                                      input logic [11:0] y);
    return {y, x, b, a, l};
  endfunction

  // Favor the ends of the range
  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_pixel();
    return pack_pixel(pick_chan(), pick_chan(), pick_chan(), pick_coord(), pick_coord());
  endfunction

  // Track the cluster sums on every accepted input item
  always @(posedge clk) begin
    cluster_mean_t res;
    if (!rst_n) begin
      acc_l = '0; acc_a = '0; acc_b = '0; acc_x = '0; acc_y = '0; acc_n = '0;
    end else if (in_tvalid && in_tready) begin
      // pixel is added before the close; drop it once the count is at its bound
      if (in_tuser && acc_n < COUNT_BOUND) begin
        acc_l = acc_l + in_tdata[7:0];
        acc_a = acc_a + in_tdata[15:8];
        acc_b = acc_b + in_tdata[23:16];
        acc_x = acc_x + in_tdata[35:24];
        acc_y = acc_y + in_tdata[47:36];
        acc_n = acc_n + 1'b1;
      end
      if (in_tlast) begin
        res.l = 8'(trunc_mean(28'(acc_l), acc_n));
        res.a = 8'(trunc_mean(28'(acc_a), acc_n));
        res.b = 8'(trunc_mean(28'(acc_b), acc_n));
        res.x = 12'(trunc_mean(acc_x, acc_n));
        res.y = 12'(trunc_mean(acc_y, acc_n));
        res.n = acc_n;
        mean_queue.insert(mean_queue.size(), res);
        acc_l = '0; acc_a = '0; acc_b = '0; acc_x = '0; acc_y = '0; acc_n = '0;
      end
    end
  end

  // Stall the output at random and check every result item
  always @(posedge clk) begin
    cluster_mean_t want;
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (mean_queue.size() == 0) begin
        $error("unexpected result item, tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = mean_queue.pop_front();
        if (out_tdata[7:0] !== want.l) begin
          $error("mean_l expected %0d actual %0d", want.l, out_tdata[7:0]);
          fail_count++;
        end
        if (out_tdata[15:8] !== want.a) begin
          $error("mean_a expected %0d actual %0d", want.a, out_tdata[15:8]);
          fail_count++;
        end
        if (out_tdata[23:16] !== want.b) begin
          $error("mean_b expected %0d actual %0d", want.b, out_tdata[23:16]);
          fail_count++;
        end
        if (out_tdata[35:24] !== want.x) begin
          $error("mean_x expected %0d actual %0d", want.x, out_tdata[35:24]);
          fail_count++;
        end
        if (out_tdata[47:36] !== want.y) begin
          $error("mean_y expected %0d actual %0d", want.y, out_tdata[47:36]);
          fail_count++;
        end
        if (out_tdata[63:48] !== want.n) begin
          $error("count expected %0d actual %0d", want.n, out_tdata[63:48]);
          fail_count++;
        end
      end
    end
  end

  // Present one item, with optional idle cycles ahead of it, and hold it until taken
  task automatic send_item(input logic [IN_DATA_W-1:0] data, input logic present,
                           input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= present;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic test_empty_clusters();
    // empty cluster right after reset, then a run of empty items closing with an empty last
    send_item(pack_pixel(8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF), 1'b0, 1'b1);
    send_item(random_pixel(), 1'b0, 1'b0);
    send_item(random_pixel(), 1'b0, 1'b0);
    send_item(random_pixel(), 1'b0, 1'b1);
  endtask

  task automatic test_single_pixel();
    send_item(pack_pixel(8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF), 1'b1, 1'b1);
    send_item(pack_pixel(8'h00, 8'h00, 8'h00, 12'h000, 12'h000), 1'b1, 1'b1);
    send_item(pack_pixel(8'h5A, 8'hA5, 8'h3C, 12'hA5A, 12'h5A5), 1'b1, 1'b1);
  endtask

  task automatic test_truncation();
    // max plus zero: every mean rounds down
    send_item(pack_pixel(8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF), 1'b1, 1'b0);
    send_item(pack_pixel(8'h00, 8'h00, 8'h00, 12'h000, 12'h000), 1'b1, 1'b1);
    // three pixels, sums not divisible by three
    send_item(pack_pixel(8'd1, 8'd2, 8'd255, 12'd1, 12'd4095), 1'b1, 1'b0);
    send_item(pack_pixel(8'd1, 8'd2, 8'd255, 12'd1, 12'd4095), 1'b1, 1'b0);
    send_item(pack_pixel(8'd0, 8'd3, 8'd254, 12'd0, 12'd4094), 1'b1, 1'b1);
  endtask

  task automatic test_mixed_closing();
    // empty items inside a cluster are ignored; the last item's pixel counts
    send_item(pack_pixel(8'd10, 8'd20, 8'd30, 12'd100, 12'd200), 1'b1, 1'b0);
    send_item(pack_pixel(8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF), 1'b0, 1'b0);
    send_item(pack_pixel(8'd20, 8'd40, 8'd60, 12'd300, 12'd400), 1'b1, 1'b0);
    send_item(pack_pixel(8'd33, 8'd44, 8'd55, 12'd666, 12'd777), 1'b1, 1'b1);
    // pixels closed by an empty last item
    send_item(pack_pixel(8'd7, 8'd8, 8'd9, 12'd4000, 12'd17), 1'b1, 1'b0);
    send_item(pack_pixel(8'd9, 8'd8, 8'd7, 12'd3000, 12'd19), 1'b1, 1'b0);
    send_item(pack_pixel(8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF), 1'b0, 1'b1);
  endtask

  task automatic test_random_clusters(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned item_goal);
    int unsigned sent;
    int unsigned size;
    int unsigned k;
    logic close_with_pixel;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < item_goal) begin
      case ($urandom_range(0, 19))
        0, 1:    size = 0;
        2:       size = $urandom_range(11, 64);
        default: size = $urandom_range(1, 10);
      endcase
      close_with_pixel = (size != 0) && $urandom_range(0, 1);
      k = close_with_pixel ? size - 1 : size;
      while (k > 0) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(random_pixel(), 1'b0, 1'b0);
          sent++;
        end
        send_item(random_pixel(), 1'b1, 1'b0);
        k--;
        sent++;
      end
      send_item(random_pixel(), close_with_pixel, 1'b1);
      sent++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_clusters();
    test_single_pixel();
    test_truncation();
    test_mixed_closing();

    test_random_clusters(0, 0, 290);
    test_random_clusters(47, 0, 290);
    test_random_clusters(0, 47, 290);
    test_random_clusters(20, 20, 290);

    in_tvalid <= 1'b0;
    while (mean_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("PASS cluster_mean_update_top");
    else
      $display("FAIL cluster_mean_update_top");
    $finish;
  end

endmodule
